FILE: hdl/flpa_pkg.sv
// Shared types and constants for the free-list page allocator.
// No dependencies; imported by free_list_page_allocator.
package flpa_pkg;

  localparam int unsigned NUM_PAGES_DEF = 1024;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned PAGE_W  = 10;
  localparam int unsigned END_W   = 11;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  localparam logic [KIND_W-1:0] KIND_AVAILABLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOCATED = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PAGE_W-1:0] page_index;
    logic [END_W-1:0]  range_end;
    logic [KIND_W-1:0] range_kind;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PAGE_W-1:0]  result_page;
    logic [COUNT_W-1:0] free_count;
  } rsp_t;

endpackage

FILE: hdl/free_list_page_allocator.sv
// Page allocator: FIFO ring of free page indices plus a per-page {kind, taken} memory.
// Empty alloc, bad range, out-of-range free and unknown op are answered from S_IDLE;
// other frees pass S_FREE_CHK, alloc S_ALLOC_RD then S_ALLOC_WR, mark S_MARK. One at a time.
// The rate is set by the page memory read-modify-write and the one-page-per-cycle mark walk.
// After reset a clearing pass writes every page entry to zero, with busy high.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
module free_list_page_allocator #(
  parameter int unsigned NUM_PAGES = flpa_pkg::NUM_PAGES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  flpa_pkg::req_t req_i,
  output logic           done_o,
  output flpa_pkg::rsp_t rsp_o
);
  import flpa_pkg::*;

  localparam int unsigned PA_W  = $clog2(NUM_PAGES);
  localparam int unsigned CNT_W = $clog2(NUM_PAGES + 1);
  localparam int unsigned PM_W  = KIND_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_FREE_CHK,
    S_MARK
  } state_e;

  state_e               state_q, state_d;
  logic [PA_W-1:0]      head_q, head_d;
  logic [PA_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [PA_W-1:0]      cur_q, cur_d;
  logic [END_W-1:0]     stop_q, stop_d;
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [PAGE_W-1:0]    pg_q, pg_d;
  logic                 full_q, full_d;
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;

  logic                 pm_we;
  logic [PA_W-1:0]      pm_waddr, pm_raddr;
  logic [PM_W-1:0]      pm_wdata, pm_rdata;
  logic                 rg_we;
  logic [PA_W-1:0]      rg_waddr, rg_raddr;
  logic [PAGE_W-1:0]    rg_wdata, rg_rdata;

  logic [31:0]          start_w, stop_w;

  function automatic logic [PA_W-1:0] ptr_inc(input logic [PA_W-1:0] p);
    return (p == PA_W'(NUM_PAGES - 1)) ? '0 : p + PA_W'(1);
  endfunction

  function automatic logic [PA_W-1:0] to_addr(input logic [PAGE_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[PA_W-1:0];
  endfunction

  function automatic logic [PAGE_W-1:0] to_page(input logic [PA_W-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[PAGE_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[COUNT_W-1:0];
  endfunction

  assign start_w = 32'(req_i.page_index);
  assign stop_w  = 32'(req_i.range_end);

  flpa_ram #(
    .WIDTH(PM_W),
    .DEPTH(NUM_PAGES)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (pm_we),
    .waddr_i(pm_waddr),
    .wdata_i(pm_wdata),
    .raddr_i(pm_raddr),
    .rdata_o(pm_rdata)
  );

  flpa_ram #(
    .WIDTH(PAGE_W),
    .DEPTH(NUM_PAGES)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (rg_we),
    .waddr_i(rg_waddr),
    .wdata_i(rg_wdata),
    .raddr_i(rg_raddr),
    .rdata_o(rg_rdata)
  );

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    stop_d   = stop_q;
    kind_d   = kind_q;
    pg_d     = pg_q;
    full_d   = full_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    pm_we    = 1'b0;
    pm_waddr = cur_q;
    pm_wdata = '0;
    pm_raddr = '0;
    rg_we    = 1'b0;
    rg_waddr = tail_q;
    rg_wdata = pg_q;
    rg_raddr = head_q;

    unique case (state_q)
      S_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = cur_q;
        pm_wdata = '0;
        if (cur_q == PA_W'(NUM_PAGES - 1)) begin
          cur_d   = '0;
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + PA_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          unique case (req_i.operation)
            OP_ALLOC: begin
              if (cnt_q == '0) begin
                done_d = 1'b1;
                rsp_d  = '{status: ST_EMPTY, result_page: '0, free_count: to_count(cnt_q)};
              end else begin
                rg_raddr = head_q;
                state_d  = S_ALLOC_RD;
              end
            end
            OP_FREE: begin
              if (start_w >= 32'(NUM_PAGES)) begin
                done_d = 1'b1;
                rsp_d  = '{status: ST_BAD, result_page: '0, free_count: to_count(cnt_q)};
              end else begin
                pg_d     = req_i.page_index;
                pm_raddr = start_w[PA_W-1:0];
                state_d  = S_FREE_CHK;
              end
            end
            OP_MARK: begin
              if (start_w >= stop_w || stop_w > 32'(NUM_PAGES)) begin
                done_d = 1'b1;
                rsp_d  = '{status: ST_BAD, result_page: '0, free_count: to_count(cnt_q)};
              end else begin
                cur_d   = start_w[PA_W-1:0];
                stop_d  = req_i.range_end;
                kind_d  = req_i.range_kind;
                full_d  = 1'b0;
                state_d = S_MARK;
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '{status: ST_OK, result_page: '0, free_count: to_count(cnt_q)};
            end
          endcase
        end
      end

      S_ALLOC_RD: begin
        // ring data is the front page; fetch its entry for the taken-bit update
        pg_d     = rg_rdata;
        pm_raddr = to_addr(rg_rdata);
        head_d   = ptr_inc(head_q);
        cnt_d    = cnt_q - CNT_W'(1);
        state_d  = S_ALLOC_WR;
      end

      S_ALLOC_WR: begin
        pm_we    = 1'b1;
        pm_waddr = to_addr(pg_q);
        pm_wdata = {pm_rdata[PM_W-1:1], 1'b1};
        done_d   = 1'b1;
        rsp_d    = '{status: ST_OK, result_page: pg_q, free_count: to_count(cnt_q)};
        state_d  = S_IDLE;
      end

      S_FREE_CHK: begin
        priority if (!pm_rdata[0]) begin
          rsp_d = '{status: ST_BAD, result_page: '0, free_count: to_count(cnt_q)};
        end else if (cnt_q == CNT_W'(NUM_PAGES)) begin
          rsp_d = '{status: ST_FULL, result_page: '0, free_count: to_count(cnt_q)};
        end else begin
          pm_we    = 1'b1;
          pm_waddr = to_addr(pg_q);
          pm_wdata = {pm_rdata[PM_W-1:1], 1'b0};
          rg_we    = 1'b1;
          rg_waddr = tail_q;
          rg_wdata = pg_q;
          tail_d   = ptr_inc(tail_q);
          cnt_d    = cnt_q + CNT_W'(1);
          rsp_d    = '{status: ST_OK, result_page: '0, free_count: to_count(cnt_d)};
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_MARK: begin
        pm_we    = 1'b1;
        pm_waddr = cur_q;
        pm_wdata = {kind_q, kind_q == KIND_ALLOCATED};
        if (kind_q == KIND_AVAILABLE) begin
          if (cnt_q == CNT_W'(NUM_PAGES)) begin
            full_d = 1'b1;
          end else begin
            rg_we    = 1'b1;
            rg_waddr = tail_q;
            rg_wdata = to_page(cur_q);
            tail_d   = ptr_inc(tail_q);
            cnt_d    = cnt_q + CNT_W'(1);
          end
        end
        if (32'(cur_q) + 32'd1 == 32'(stop_q)) begin
          done_d  = 1'b1;
          rsp_d   = '{status: full_d ? ST_FULL : ST_OK, result_page: '0,
                      free_count: to_count(cnt_d)};
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + PA_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      cur_q   <= '0;
      stop_q  <= '0;
      kind_q  <= '0;
      pg_q    <= '0;
      full_q  <= 1'b0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      stop_q  <= stop_d;
      kind_q  <= kind_d;
      pg_q    <= pg_d;
      full_q  <= full_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // occupancy never exceeds the ring
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_PAGES))
    else $error("free count beyond ring depth");

  // empty or full ring means the pointers meet
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_W'(NUM_PAGES)) |-> head_q == tail_q)
    else $error("ring pointers disagree with free count");

  // one push or pop per cycle at most
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CNT_W'(1) ||
    cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("free count jumped");

  // an empty report only ever carries a zero count
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> rsp_o.free_count == '0)
    else $error("empty status with non-zero count");

endmodule

FILE: hdl/flpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module flpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for free_list_page_allocator: directed corner cases, then three
// phases of random transactions checked against an in-bench model of the free ring.
// Depends on flpa_pkg and free_list_page_allocator.
module tb_top;
  import flpa_pkg::*;

  localparam int unsigned PAGES      = NUM_PAGES_DEF;
  localparam int unsigned CYCLE_CAP  = 2_000_000;
  localparam int unsigned SETTLE     = 20;
  localparam int unsigned PHASE_ITEMS = 467;

  // operation code the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KERNEL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HW     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HEAP   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD6  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7  = 3'd7;

  class page_alloc_scoreboard;
    logic [PAGE_W-1:0] ring_mem [PAGES];
    bit                taken [PAGES];
    int unsigned       head, tail, count;
    rsp_t              pending_q[$];
    int unsigned       handed_q[$];   // pages given out, candidates for a legal free
    int unsigned       errors, checked;
    int unsigned       status_seen [4];

    function new();
      head = 0;
      tail = 0;
      count = 0;
      errors = 0;
      checked = 0;
      foreach (taken[i]) taken[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit ring_append(int unsigned pg);
      if (count >= PAGES) return 1'b0;
      ring_mem[tail] = pg[PAGE_W-1:0];
      tail = (tail + 1 == PAGES) ? 0 : tail + 1;
      count++;
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      int unsigned pg, lo, hi;
      e  = '0;
      lo = 32'(r.page_index);
      hi = 32'(r.range_end);
      case (r.operation)
        OP_ALLOC: begin
          if (count == 0) begin
            e.status = ST_EMPTY;
          end else begin
            pg = 32'(ring_mem[head]);
            head = (head + 1 == PAGES) ? 0 : head + 1;
            count--;
            taken[pg] = 1'b1;
            e.result_page = pg[PAGE_W-1:0];
            handed_q.push_back(pg);
          end
        end
        OP_FREE: begin
          if (!taken[lo]) begin
            e.status = ST_BAD;
          end else if (count >= PAGES) begin
            e.status = ST_FULL;
          end else begin
            taken[lo] = 1'b0;
            void'(ring_append(lo));
          end
        end
        OP_MARK: begin
          if (lo >= hi || hi > PAGES) begin
            e.status = ST_BAD;
          end else begin
            for (pg = lo; pg < hi; pg++) begin
              taken[pg] = (r.range_kind == KIND_ALLOCATED);
              // an available page that does not fit keeps its kind but is dropped
              if (r.range_kind == KIND_AVAILABLE && !ring_append(pg)) e.status = ST_FULL;
            end
          end
        end
        default: ;
      endcase
      e.free_count = count[COUNT_W-1:0];
      status_seen[e.status]++;
      pending_q.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with none pending: status %0d page %0d count %0d",
                         got.status, got.result_page, got.free_count));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.result_page !== want.result_page)
        report($sformatf("result_page got %0d want %0d", got.result_page, want.result_page));
      if (got.free_count !== want.free_count)
        report($sformatf("free_count got %0d want %0d", got.free_count, want.free_count));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  rsp_t        rsp;
  int unsigned cycles;
  int unsigned n_directed, n_random;

  page_alloc_scoreboard sb = new();

  free_list_page_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done) sb.check_result(rsp);
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Presents one transaction, optionally after random idle cycles, and waits until busy drops.
  task automatic send_req(req_t r, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic req_t mk(logic [OP_W-1:0] op, int unsigned pi, int unsigned re,
                              logic [KIND_W-1:0] kind);
    req_t r;
    r.operation  = op;
    r.page_index = pi[PAGE_W-1:0];
    r.range_end  = re[END_W-1:0];
    r.range_kind = kind;
    return r;
  endfunction

  // Biased towards allocation while the ring holds more than target pages.
  function automatic req_t random_request(int unsigned target);
    req_t        r;
    int unsigned roll, len, idx, re;
    bit          above;
    r.operation  = OP_ALLOC;
    r.page_index = PAGE_W'($urandom_range(PAGES - 1));
    r.range_end  = END_W'($urandom_range(2047));
    r.range_kind = KIND_W'($urandom_range(7));
    above = sb.count > target;
    roll  = $urandom_range(99);
    if (roll < (above ? 80 : 35)) begin
      r.operation = OP_ALLOC;
    end else if (roll < (above ? 88 : 65)) begin
      r.operation = OP_FREE;
      if (sb.handed_q.size() != 0 && $urandom_range(9) < 8) begin
        idx = $urandom_range(sb.handed_q.size() - 1);
        r.page_index = PAGE_W'(sb.handed_q[idx]);
        sb.handed_q.delete(idx);
      end
    end else if (roll < 95) begin
      r.operation = OP_MARK;
      roll = $urandom_range(99);
      len = (roll < 90) ? $urandom_range(1, 6) :
            (roll < 98) ? $urandom_range(7, 64) : $urandom_range(65, PAGES);
      re = 32'(r.page_index) + len;
      if (re > PAGES && $urandom_range(9) != 0) re = PAGES;
      // now and then keep the raw end, mostly a bad range
      if ($urandom_range(19) != 0) r.range_end = re[END_W-1:0];
      roll = $urandom_range(99);
      if (roll < 40) r.range_kind = KIND_AVAILABLE;
      else if (roll < 55) r.range_kind = KIND_ALLOCATED;
    end else begin
      r.operation = OP_UNUSED;
    end
    return r;
  endfunction

  initial begin
    req_t        directed_q[$];
    int unsigned idle_by_phase [3];
    int unsigned target_by_phase [3];
    idle_by_phase   = '{27, 61, 0};
    target_by_phase = '{64, 512, 8};
    n_directed = 0;
    n_random   = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_q.push_back(mk(OP_ALLOC, 0, 0, KIND_UNUSED));          // empty ring
    directed_q.push_back(mk(OP_FREE, 0, 0, KIND_UNUSED));           // page never allocated
    directed_q.push_back(mk(OP_MARK, 5, 5, KIND_AVAILABLE));        // empty range
    directed_q.push_back(mk(OP_MARK, 1000, 1025, KIND_AVAILABLE));  // end past last page
    directed_q.push_back(mk(OP_MARK, 1023, 2047, KIND_RSVD7));
    directed_q.push_back(mk(OP_UNUSED, 1023, 2047, KIND_RSVD7));
    directed_q.push_back(mk(OP_MARK, 0, PAGES, KIND_AVAILABLE));    // fills the ring
    directed_q.push_back(mk(OP_MARK, 1020, PAGES, KIND_AVAILABLE)); // overflow, pages skipped
    directed_q.push_back(mk(OP_MARK, 0, 4, KIND_ALLOCATED));
    directed_q.push_back(mk(OP_FREE, 2, 0, KIND_UNUSED));           // ring full on free
    directed_q.push_back(mk(OP_ALLOC, 0, 0, KIND_UNUSED));          // taken page at the front
    directed_q.push_back(mk(OP_FREE, 2, 0, KIND_UNUSED));
    directed_q.push_back(mk(OP_ALLOC, 0, 0, KIND_UNUSED));
    directed_q.push_back(mk(OP_ALLOC, 0, 0, KIND_UNUSED));
    directed_q.push_back(mk(OP_FREE, 1, 0, KIND_UNUSED));
    directed_q.push_back(mk(OP_MARK, 512, 520, KIND_HEAP));
    directed_q.push_back(mk(OP_MARK, 600, 601, KIND_KERNEL));
    directed_q.push_back(mk(OP_MARK, 700, 702, KIND_HW));
    directed_q.push_back(mk(OP_MARK, 800, 803, KIND_RSVD6));
    directed_q.push_back(mk(OP_MARK, 900, 904, KIND_UNUSED));
    directed_q.push_back(mk(OP_MARK, 1023, PAGES, KIND_AVAILABLE)); // re-mark a page on the ring
    directed_q.push_back(mk(OP_FREE, 1023, 0, KIND_UNUSED));
    directed_q.push_back(mk(OP_FREE, 3, 0, KIND_UNUSED));
    directed_q.push_back(mk(OP_ALLOC, 0, 0, KIND_UNUSED));
    foreach (directed_q[i]) begin
      send_req(directed_q[i], 0);
      n_directed++;
    end
    pause_until_drained();

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_req(random_request(target_by_phase[ph]), idle_by_phase[ph]);
        n_random++;
      end
      pause_until_drained();
    end
    repeat (SETTLE) @(posedge clk_i);

    $display("ran %0d transactions (%0d directed, %0d random), %0d results checked",
             n_directed + n_random, n_directed, n_random, sb.checked);
    $display("statuses: ok %0d, empty %0d, bad %0d, ring full %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_BAD], sb.status_seen[ST_FULL]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
